// ===== hw/rtl/dsng_pkg.sv =====
package dsng_pkg;

    typedef enum logic [1:0] {
        PH_SEED    = 2'd0,
        PH_DIAMOND = 2'd1,
        PH_SQUARE  = 2'd2
    } phase_t;

    localparam int unsigned MOD_ONE  = 8388608;
    localparam int unsigned MOD_C08  = 6710886;
    localparam int unsigned MOD_C03  = 2516582;

    // One classified write handed from the sequencer to the datapath
    typedef struct packed {
        phase_t      phase;
        logic        second;
        logic [23:0] rnd;
        logic [10:0] step;
        logic [23:0] scale;
        logic        last;
    } job_t;

    function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
        logic signed [23:0] r;
        if (v > 64'sd8388607)
        begin
            r = 24'sd8388607;
        end
        else if (v < -64'sd8388608)
        begin
            r = -24'sd8388608;
        end
        else
        begin
            r = v[23:0];
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/diamond_square_noise_grid.sv =====
// channel  | handshake        | payload
// input    | push / full      | random_fraction
// result   | pop / empty      | x_pos, y_pos, height, last
// config   | cfg_valid/ready  | cfg_data (feature_size_log2)
// A seed point skips the neighbour reads in the back part; diamond and square points
// make four reads through the single grid memory read port, take the data returns
// and then write back.
// The front part queues one job, so input is taken while the back part works.
// Reset restarts the run at the seed phase; grid contents are undefined
// until written. Stalling pop holds the result and then the back part.
module diamond_square_noise_grid #(
    parameter int GRID_SIZE = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [23:0] random_fraction,
    input  logic        pop,
    output logic        empty,
    output logic [6:0]  x_pos,
    output logic [6:0]  y_pos,
    output logic signed [23:0] height,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_data
);

    localparam int CW = $clog2(GRID_SIZE);

    dsng_pkg::job_t     job, q_reg;
    logic [CW-1:0]      jx, jy, qx_reg, qy_reg, rx, ry;
    logic               q_valid_reg, take, res_valid, job_take;
    logic signed [23:0] rh;

    assign full      = q_valid_reg;
    assign take      = push && !full;
    assign cfg_ready = 1'b1;

    dsng_seq #(.GRID_SIZE(GRID_SIZE), .CW(CW)) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_data (cfg_data),
        .take     (take),
        .rnd      (random_fraction),
        .job      (job),
        .jx       (jx),
        .jy       (jy)
    );

    // hold one classified job between the parts
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            q_reg  <= job;
            qx_reg <= jx;
            qy_reg <= jy;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            q_valid_reg <= 1'b1;
        end
        else if (job_take)
        begin
            q_valid_reg <= 1'b0;
        end
    end

    dsng_exec #(.GRID_SIZE(GRID_SIZE), .CW(CW)) u_exec (
        .clk      (clk),
        .rst_n    (rst_n),
        .job_valid(q_valid_reg),
        .job      (q_reg),
        .jx       (qx_reg),
        .jy       (qy_reg),
        .job_take (job_take),
        .res_valid(res_valid),
        .res_x    (rx),
        .res_y    (ry),
        .res_h    (rh),
        .res_last (last),
        .res_take (pop && res_valid)
    );

    assign empty  = !res_valid;
    assign x_pos  = 7'(rx);
    assign y_pos  = 7'(ry);
    assign height = rh;

    // a taken beat always leaves the queue holding a job
    assert property (@(posedge clk) disable iff (!rst_n)
        take |=> q_valid_reg)
        else $error("queue lost a beat");
    // a stalled result holds its value
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(height) && $stable(x_pos)))
        else $error("result changed under stall");

endmodule

// ===== hw/rtl/dsng_ram.sv =====
module dsng_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/dsng_seq.sv =====
// Front part: walks the lattice, one job per accepted beat.
module dsng_seq #(
    parameter int GRID_SIZE = 128,
    parameter int CW        = 7
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [2:0]          cfg_data,
    input  logic                take,
    input  logic [23:0]         rnd,
    output dsng_pkg::job_t      job,
    output logic [CW-1:0]       jx,
    output logic [CW-1:0]       jy
);

    localparam int SW = CW + 1;

    logic [2:0]       fs_reg;
    dsng_pkg::phase_t ph_reg, ph_next;
    logic [SW-1:0]    step_reg, step_next;
    logic [SW:0]      col_reg, col_next, row_reg, row_next;
    logic             sec_reg, sec_next;
    logic [23:0]      scale_reg, scale_next, mod_reg, mod_next;
    logic [47:0]      sprod, mprod;
    logic [SW-1:0]    eff;
    logic             wrap_c, wrap_r, adv, lastj;

    function automatic logic [SW-1:0] eff_of(input logic [2:0] l);
        logic [2:0]  ll;
        logic [10:0] s;
        ll = (l == 3'd0) ? 3'd1 : l;
        s  = 11'd1 << ll;
        if (s > 11'(GRID_SIZE))
        begin
            s = 11'(GRID_SIZE);
        end
        return SW'(s);
    endfunction

    assign eff = eff_of(cfg_valid ? cfg_data : fs_reg);

    always_comb
    begin
        ph_next    = ph_reg;
        step_next  = step_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        sec_next   = sec_reg;
        scale_next = scale_reg;
        mod_next   = mod_reg;
        lastj      = 1'b0;
        adv        = (ph_reg != dsng_pkg::PH_SQUARE) || sec_reg;
        wrap_c     = (col_reg + (SW+1)'(step_reg)) >= (SW+1)'(GRID_SIZE);
        wrap_r     = (row_reg + (SW+1)'(step_reg)) >= (SW+1)'(GRID_SIZE);
        sprod      = 48'(scale_reg) * 48'(mod_reg + 24'(dsng_pkg::MOD_C08));
        mprod      = 48'(mod_reg) * 48'(dsng_pkg::MOD_C03);
        if (ph_reg == dsng_pkg::PH_SQUARE)
        begin
            sec_next = ~sec_reg;
        end
        if (adv)
        begin
            if (wrap_c)
            begin
                col_next = '0;
                row_next = wrap_r ? '0 : row_reg + (SW+1)'(step_reg);
            end
            else
            begin
                col_next = col_reg + (SW+1)'(step_reg);
            end
            if (wrap_c && wrap_r)
            begin
                case (ph_reg)
                    dsng_pkg::PH_SEED,
                    dsng_pkg::PH_DIAMOND:
                    begin
                        ph_next  = (ph_reg == dsng_pkg::PH_SEED) ?
                                   dsng_pkg::PH_DIAMOND : dsng_pkg::PH_SQUARE;
                        sec_next = 1'b0;
                    end
                    default:
                    begin
                        scale_next = ((sprod + 48'd4194304) >> 23) > 48'd16777215 ?
                                     24'hFFFFFF : 24'((sprod + 48'd4194304) >> 23);
                        mod_next   = 24'((mprod + 48'd4194304) >> 23);
                        step_next  = step_reg >> 1;
                        ph_next    = dsng_pkg::PH_DIAMOND;
                        if (step_reg <= SW'(2))
                        begin
                            lastj      = 1'b1;
                            ph_next    = dsng_pkg::PH_SEED;
                            step_next  = eff;
                            scale_next = 24'((25'd1 << 24) / GRID_SIZE);
                            mod_next   = 24'(dsng_pkg::MOD_ONE);
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg    <= 3'd4;
            ph_reg    <= dsng_pkg::PH_SEED;
            step_reg  <= eff_of(3'd4);
            col_reg   <= '0;
            row_reg   <= '0;
            sec_reg   <= 1'b0;
            scale_reg <= 24'((25'd1 << 24) / GRID_SIZE);
            mod_reg   <= 24'(dsng_pkg::MOD_ONE);
        end
        else if (cfg_valid)
        begin
            fs_reg    <= cfg_data;
            ph_reg    <= dsng_pkg::PH_SEED;
            step_reg  <= eff;
            col_reg   <= '0;
            row_reg   <= '0;
            sec_reg   <= 1'b0;
            scale_reg <= 24'((25'd1 << 24) / GRID_SIZE);
            mod_reg   <= 24'(dsng_pkg::MOD_ONE);
        end
        else if (take)
        begin
            ph_reg    <= ph_next;
            step_reg  <= step_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            sec_reg   <= sec_next;
            scale_reg <= scale_next;
            mod_reg   <= mod_next;
        end
    end

    assign job.phase  = ph_reg;
    assign job.second = sec_reg;
    assign job.rnd    = rnd;
    assign job.step   = 11'(step_reg);
    assign job.scale  = scale_reg;
    assign job.last   = lastj;
    assign jx         = col_reg[CW-1:0];
    assign jy         = row_reg[CW-1:0];

endmodule

// ===== hw/rtl/dsng_exec.sv =====
// Back part: four neighbour reads (none for seed points), blend, write back, one result per job.
module dsng_exec #(
    parameter int GRID_SIZE = 128,
    parameter int CW        = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    input  dsng_pkg::job_t     job,
    input  logic [CW-1:0]      jx,
    input  logic [CW-1:0]      jy,
    output logic               job_take,
    output logic               res_valid,
    output logic [CW-1:0]      res_x,
    output logic [CW-1:0]      res_y,
    output logic signed [23:0] res_h,
    output logic               res_last,
    input  logic               res_take
);

    localparam int AW = 2 * CW;

    logic [2:0]         cnt_reg, cnt_next;
    logic               busy_reg;
    dsng_pkg::job_t     j_reg;
    logic [CW-1:0]      x_reg, y_reg, wx, wy, hs, ss;
    logic signed [26:0] sum_reg;
    logic signed [37:0] cs_reg;
    logic signed [63:0] prod_reg, pmul, acc;
    logic [AW-1:0]      raddr;
    logic [23:0]        rdata;
    logic signed [23:0] val;
    logic               we, rvalid, fin;
    logic [4:0]         sh;
    logic signed [25:0] cen;

    assign ss  = CW'(j_reg.step);
    assign hs  = CW'(j_reg.step >> 1);
    assign cen = $signed({1'b0, j_reg.rnd, 1'b0}) - 26'sd16777216;

    // neighbour address for read cnt
    always_comb
    begin
        logic [CW-1:0] ax, ay;
        ax = x_reg;
        ay = y_reg;
        case (cnt_reg)
            3'd0: begin ax = x_reg; ay = y_reg; end
            3'd1:
            begin
                if (j_reg.phase == dsng_pkg::PH_DIAMOND)
                begin
                    ax = x_reg + ss;
                end
                else
                begin
                    ax = x_reg + hs; ay = y_reg + hs;
                end
            end
            3'd2:
            begin
                if (j_reg.phase == dsng_pkg::PH_DIAMOND)
                begin
                    ay = y_reg + ss;
                end
                else if (!j_reg.second)
                begin
                    ax = x_reg + ss;
                end
                else
                begin
                    ay = y_reg + ss;
                end
            end
            default:
            begin
                if (j_reg.phase == dsng_pkg::PH_DIAMOND)
                begin
                    ax = x_reg + ss; ay = y_reg + ss;
                end
                else if (!j_reg.second)
                begin
                    ax = x_reg + hs; ay = y_reg - hs;
                end
                else
                begin
                    ax = x_reg - hs; ay = y_reg + hs;
                end
            end
        endcase
        raddr = {ay, ax};
    end

    always_comb
    begin
        wx = x_reg;
        wy = y_reg;
        case (j_reg.phase)
            dsng_pkg::PH_DIAMOND: begin wx = x_reg + hs; wy = y_reg + hs; end
            dsng_pkg::PH_SQUARE:
            begin
                if (!j_reg.second) wx = x_reg + hs; else wy = y_reg + hs;
            end
            default: ;
        endcase
    end

    assign sh  = (j_reg.phase == dsng_pkg::PH_DIAMOND) ? 5'd28 : 5'd29;
    assign acc = (j_reg.phase == dsng_pkg::PH_SEED) ?
                 64'(cen) + 64'sd8 >>> 4 :
                 ((64'(sum_reg) <<< (sh - 5'd2)) + prod_reg
                  + (64'sd1 <<< (sh - 5'd1))) >>> sh;
    assign val = dsng_pkg::sat24(acc);

    // random offset: cen * step in cnt 0, times scale in cnt 1
    assign pmul = 64'(cs_reg) * 64'($signed({1'b0, j_reg.scale}));

    // cnt 0..3 reads, 1..4 data returns, 6 finish (write and result)
    assign fin      = busy_reg && cnt_reg == 3'd6 && (!res_valid || res_take);
    assign we       = fin;
    assign job_take = job_valid && !busy_reg;
    assign rvalid   = busy_reg && cnt_reg >= 3'd1 && cnt_reg <= 3'd4;
    assign cnt_next = (j_reg.phase == dsng_pkg::PH_SEED && cnt_reg == 3'd0) ? 3'd6
                    : cnt_reg + 3'd1;

    dsng_ram #(.WIDTH(24), .DEPTH(GRID_SIZE * GRID_SIZE)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr ({wy, wx}),
        .wdata (val),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            j_reg    <= job;
            x_reg    <= jx;
            y_reg    <= jy;
            sum_reg  <= '0;
        end
        else if (rvalid)
        begin
            sum_reg <= sum_reg + 27'($signed(rdata));
        end
        if (busy_reg && cnt_reg == 3'd0)
        begin
            cs_reg <= 38'(cen) * 38'($signed({1'b0, j_reg.step}));
        end
        if (busy_reg && cnt_reg == 3'd1)
        begin
            prod_reg <= pmul;
        end
        if (we)
        begin
            res_x    <= wx;
            res_y    <= wy;
            res_h    <= val;
            res_last <= j_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            res_valid <= 1'b0;
        end
        else
        begin
            if (job_take)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (fin)
            begin
                busy_reg <= 1'b0;
            end
            else if (busy_reg && cnt_reg != 3'd6)
            begin
                cnt_reg <= cnt_next;
            end
            if (fin)
            begin
                res_valid <= 1'b1;
            end
            else if (res_take)
            begin
                res_valid <= 1'b0;
            end
        end
    end

endmodule
